[rtl/fsi_pkg.sv]
// Shared types, codes and helpers for the flight setpoint integrator.
package fsi_pkg;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_YAW_RATE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_PERIOD      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEASH_DISTANCE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CLIMB_SPEED  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PLANAR_SPEED = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HOVER_THROTTLE   = 3'd5;

   // flight modes
   localparam logic [2:0] MODE_DIR4 = 3'd0;
   localparam logic [2:0] MODE_DIR6 = 3'd1;
   localparam logic [2:0] MODE_ALT4 = 3'd2;
   localparam logic [2:0] MODE_ALT6 = 3'd3;
   localparam logic [2:0] MODE_VEL4 = 3'd4;
   localparam logic [2:0] MODE_VEL6 = 3'd5;
   localparam logic [2:0] MODE_POS4 = 3'd6;
   localparam logic [2:0] MODE_POS6 = 3'd7;

   // shared multiplier and post-adder widths
   localparam int MA_W  = 34;
   localparam int MB_W  = 32;
   localparam int MP_W  = MA_W + MB_W;
   localparam int SUM_W = MP_W + 1;

   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sh7FFF_FFFF);
   localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-64'sh8000_0000);

   typedef struct packed {
      logic               active;
      logic [2:0]         fly_mode;
      logic signed [15:0] roll_axis;
      logic signed [15:0] pitch_axis;
      logic signed [15:0] yaw_axis;
      logic signed [15:0] throttle_stick;
      logic signed [31:0] est_x;
      logic signed [31:0] est_y;
      logic signed [31:0] est_yaw;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sp_x;
      logic signed [31:0] sp_y;
      logic signed [31:0] sp_z;
      logic signed [31:0] sp_yaw;
      logic signed [15:0] sp_roll;
      logic signed [15:0] sp_pitch;
      logic signed [15:0] thrust_x;
      logic signed [15:0] thrust_y;
      logic signed [15:0] thrust_z;
      logic signed [31:0] x_speed_cmd;
      logic signed [31:0] y_speed_cmd;
      logic [4:0]         enable_mask;
   } rsp_type;

   function automatic logic [4:0] mode_mask(input logic [2:0] mode);
      logic [4:0] m;
      case (mode)
         MODE_DIR4: m = 5'h02;
         MODE_DIR6: m = 5'h03;
         MODE_ALT4: m = 5'h06;
         MODE_ALT6: m = 5'h07;
         MODE_VEL4: m = 5'h0E;
         MODE_VEL6: m = 5'h0F;
         MODE_POS4: m = 5'h16;
         MODE_POS6: m = 5'h17;
         default:   m = 5'h00;
      endcase
      return m;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [31:0] r;
      if (v > SAT_HI) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < SAT_LO) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // negation of a Q1.14 value; the most negative code maps to the most positive
   function automatic logic signed [15:0] neg16(input logic signed [15:0] v);
      logic signed [15:0] r;
      if (v == 16'sh8000) begin
         r = 16'sh7FFF;
      end else begin
         r = -v;
      end
      return r;
   endfunction

endpackage

[rtl/flight_setpoint_integrator_top.sv]
// Flight setpoint integrator: sticks and mode in, controller setpoints out.
//
// Usage:
//  - req channel (valid/ready) carries one control tick word: active flag,
//    flight mode, four sticks and the X, Y, yaw estimates.
//  - rsp channel (valid/ready) returns one word per tick: the full setpoint
//    state after the update.
//  - csr channel (valid/ready, always ready) writes the six tuning registers
//    by index; write only while no tick is in flight.
//  - One tick is worked on at a time by a single shared multiplier and
//    post adder under a small sequencer. The result is valid in the cycle
//    after accept when inactive; a position mode runs the speed, XY, Z and
//    yaw steps in that order. Z and yaw each take up to two multiplier passes
//    (stick x tick period, then x gain), the second skipped at hover (Z) or low throttle (yaw).
//  - req_ready is high only while idle; the next tick is taken in the
//    cycle after the result word is taken.
//  - A stalled receiver simply holds the result word and the block.
//  - Synchronous reset clears all setpoints, the mask and the registers.
module flight_setpoint_integrator_top
   import fsi_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SPX   = 4'd1;
   localparam logic [3:0] ST_SPX_W = 4'd2;
   localparam logic [3:0] ST_SPY   = 4'd3;
   localparam logic [3:0] ST_SPY_W = 4'd4;
   localparam logic [3:0] ST_XYX   = 4'd5;
   localparam logic [3:0] ST_XYX_W = 4'd6;
   localparam logic [3:0] ST_XYY   = 4'd7;
   localparam logic [3:0] ST_XYY_W = 4'd8;
   localparam logic [3:0] ST_Z1    = 4'd9;
   localparam logic [3:0] ST_Z2    = 4'd10;
   localparam logic [3:0] ST_Z_W   = 4'd11;
   localparam logic [3:0] ST_Y1    = 4'd12;
   localparam logic [3:0] ST_Y2    = 4'd13;
   localparam logic [3:0] ST_Y_W   = 4'd14;
   localparam logic [3:0] ST_OUT   = 4'd15;

   logic [3:0] state_ff, state_in;

   // tuning registers
   logic [30:0]        yaw_rate_ff;
   logic [15:0]        tick_ff;
   logic [30:0]        leash_ff;
   logic [30:0]        climb_ff;
   logic [30:0]        planar_ff;
   logic signed [15:0] hover_ff;

   // setpoint state
   logic signed [31:0] sp_x_ff, sp_x_in, sp_y_ff, sp_y_in;
   logic signed [31:0] sp_z_ff, sp_z_in, sp_yaw_ff, sp_yaw_in;
   logic signed [31:0] spd_x_ff, spd_x_in, spd_y_ff, spd_y_in;
   logic signed [15:0] roll_ff, roll_in, pitch_ff, pitch_in;
   logic signed [15:0] xthr_ff, xthr_in, ythr_ff, ythr_in, zthr_ff, zthr_in;
   logic [4:0]         mask_ff, mask_in;

   // latched tick word
   logic [2:0]         in_mode_ff;
   logic signed [15:0] in_roll_ff, in_pitch_ff, in_ystk_ff, in_thr_ff;
   logic signed [31:0] in_ex_ff, in_ey_ff, in_eyaw_ff;

   // shared multiplier
   logic signed [MA_W-1:0] mul_a;
   logic signed [MB_W-1:0] mul_b;
   logic                   mul_en;
   logic signed [MP_W-1:0] prod_in, prod_ff;

   // post adder
   logic [4:0]              sh;
   logic                    sub;
   logic signed [SUM_W-1:0] base;
   logic signed [MP_W-1:0]  bias, trunc;
   logic signed [SUM_W-1:0] post_sum;
   logic signed [31:0]      post_sat;

   logic signed [17:0] off;
   logic signed [21:0] off10;
   logic signed [19:0] thr10;
   logic               z_move, low_thr;
   logic signed [34:0] x_hi, x_lo, y_hi, y_lo, spx_ext, spy_ext;
   logic               x_above, x_below, y_above, y_below;
   logic               req_acc;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign csr_ready = 1'b1;
   assign req_acc   = req_valid && req_ready;

   assign off     = $signed({{2{in_thr_ff[15]}}, in_thr_ff})
                    - $signed({{2{hover_ff[15]}}, hover_ff});
   assign off10   = $signed({{4{off[17]}}, off}) * 22'sd10;
   assign z_move  = (off10 > 22'sd16384) || (off10 < -22'sd16384);
   assign thr10   = $signed({{4{in_thr_ff[15]}}, in_thr_ff}) * 20'sd10;
   assign low_thr = (thr10 < 20'sd16384);

   // leash bounds, exact
   assign x_hi    = $signed({{3{in_ex_ff[31]}}, in_ex_ff}) + $signed({4'b0, leash_ff});
   assign x_lo    = $signed({{3{in_ex_ff[31]}}, in_ex_ff}) - $signed({4'b0, leash_ff});
   assign y_hi    = $signed({{3{in_ey_ff[31]}}, in_ey_ff}) + $signed({4'b0, leash_ff});
   assign y_lo    = $signed({{3{in_ey_ff[31]}}, in_ey_ff}) - $signed({4'b0, leash_ff});
   assign spx_ext = $signed({{3{sp_x_ff[31]}}, sp_x_ff});
   assign spy_ext = $signed({{3{sp_y_ff[31]}}, sp_y_ff});
   assign x_above = spx_ext > x_hi;
   assign x_below = spx_ext < x_lo;
   assign y_above = spy_ext > y_hi;
   assign y_below = spy_ext < y_lo;

   // operand select
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b0;
      case (state_ff)
         ST_SPX: begin
            mul_a  = -$signed({{(MA_W-16){in_pitch_ff[15]}}, in_pitch_ff});
            mul_b  = $signed({{(MB_W-31){1'b0}}, planar_ff});
            mul_en = 1'b1;
         end
         ST_SPY: begin
            mul_a  = $signed({{(MA_W-16){in_roll_ff[15]}}, in_roll_ff});
            mul_b  = $signed({{(MB_W-31){1'b0}}, planar_ff});
            mul_en = 1'b1;
         end
         ST_XYX: begin
            mul_a  = $signed({{(MA_W-32){spd_x_ff[31]}}, spd_x_ff});
            mul_b  = $signed({{(MB_W-16){1'b0}}, tick_ff});
            mul_en = 1'b1;
         end
         ST_XYY: begin
            mul_a  = $signed({{(MA_W-32){spd_y_ff[31]}}, spd_y_ff});
            mul_b  = $signed({{(MB_W-16){1'b0}}, tick_ff});
            mul_en = 1'b1;
         end
         ST_Z1: begin
            mul_a  = $signed({{(MA_W-18){off[17]}}, off});
            mul_b  = $signed({{(MB_W-16){1'b0}}, tick_ff});
            mul_en = 1'b1;
         end
         ST_Y1: begin
            mul_a  = $signed({{(MA_W-16){in_ystk_ff[15]}}, in_ystk_ff});
            mul_b  = $signed({{(MB_W-16){1'b0}}, tick_ff});
            mul_en = 1'b1;
         end
         ST_Z2: begin
            // stick x tick period fits MA_W bits
            mul_a  = prod_ff[MA_W-1:0];
            mul_b  = $signed({{(MB_W-31){1'b0}}, climb_ff});
            mul_en = 1'b1;
         end
         ST_Y2: begin
            mul_a  = prod_ff[MA_W-1:0];
            mul_b  = $signed({{(MB_W-31){1'b0}}, yaw_rate_ff});
            mul_en = 1'b1;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // truncate toward zero, then add to the selected setpoint (subtract for Z, add to zero for the speeds) and saturate
   always_comb begin
      sh   = 5'd30;
      sub  = 1'b0;
      base = '0;
      case (state_ff)
         ST_SPX_W, ST_SPY_W: begin
            sh = 5'd14;
         end
         ST_XYX_W: begin
            sh   = 5'd16;
            base = SUM_W'(sp_x_ff);
         end
         ST_XYY_W: begin
            sh   = 5'd16;
            base = SUM_W'(sp_y_ff);
         end
         ST_Z_W: begin
            sub  = 1'b1;
            base = SUM_W'(sp_z_ff);
         end
         ST_Y_W: begin
            base = SUM_W'(sp_yaw_ff);
         end
         default: begin
            sh = 5'd30;
         end
      endcase
   end

   assign bias     = prod_ff[MP_W-1] ? ((MP_W'(1) <<< sh) - MP_W'(1)) : '0;
   assign trunc    = (prod_ff + bias) >>> sh;
   assign post_sum = sub ? (base - SUM_W'(trunc)) : (base + SUM_W'(trunc));
   assign post_sat = sat32(post_sum);

   // sequencer and state update
   always_comb begin
      state_in  = state_ff;
      sp_x_in   = sp_x_ff;
      sp_y_in   = sp_y_ff;
      sp_z_in   = sp_z_ff;
      sp_yaw_in = sp_yaw_ff;
      spd_x_in  = spd_x_ff;
      spd_y_in  = spd_y_ff;
      roll_in   = roll_ff;
      pitch_in  = pitch_ff;
      xthr_in   = xthr_ff;
      ythr_in   = ythr_ff;
      zthr_in   = zthr_ff;
      mask_in   = mask_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (!req_data.active) begin
                  state_in = ST_OUT;
               end else begin
                  mask_in = mode_mask(req_data.fly_mode);
                  case (req_data.fly_mode)
                     MODE_DIR4: begin
                        roll_in  = req_data.roll_axis;
                        pitch_in = req_data.pitch_axis;
                        zthr_in  = neg16(req_data.throttle_stick);
                     end
                     MODE_DIR6: begin
                        xthr_in = neg16(req_data.pitch_axis);
                        ythr_in = req_data.roll_axis;
                        zthr_in = neg16(req_data.throttle_stick);
                     end
                     MODE_ALT4: begin
                        roll_in  = req_data.roll_axis;
                        pitch_in = req_data.pitch_axis;
                     end
                     MODE_ALT6: begin
                        roll_in  = '0;
                        pitch_in = '0;
                        xthr_in  = neg16(req_data.pitch_axis);
                        ythr_in  = req_data.roll_axis;
                     end
                     default: begin
                        roll_in = roll_ff;
                     end
                  endcase
                  if (req_data.fly_mode[2]) begin
                     state_in = ST_SPX;
                  end else if (req_data.fly_mode[1]) begin
                     state_in = ST_Z1;
                  end else begin
                     state_in = ST_Y1;
                  end
               end
            end
         end
         ST_SPX: state_in = ST_SPX_W;
         ST_SPX_W: begin
            spd_x_in = post_sat;
            state_in = ST_SPY;
         end
         ST_SPY: state_in = ST_SPY_W;
         ST_SPY_W: begin
            spd_y_in = post_sat;
            state_in = in_mode_ff[1] ? ST_XYX : ST_Z1;
         end
         ST_XYX: state_in = ST_XYX_W;
         ST_XYX_W: begin
            if (x_above) begin
               sp_x_in  = sat32(SUM_W'(x_hi));
               spd_x_in = '0;
               state_in = ST_XYY;
            end else if (x_below) begin
               // lower X clamp skips the whole Y step
               sp_x_in  = sat32(SUM_W'(x_lo));
               spd_x_in = '0;
               state_in = ST_Z1;
            end else begin
               sp_x_in  = post_sat;
               state_in = ST_XYY;
            end
         end
         ST_XYY: state_in = ST_XYY_W;
         ST_XYY_W: begin
            if (y_above) begin
               sp_y_in  = sat32(SUM_W'(y_hi));
               spd_y_in = '0;
            end else if (y_below) begin
               sp_y_in  = sat32(SUM_W'(y_lo));
               spd_y_in = '0;
            end else begin
               sp_y_in = post_sat;
            end
            state_in = ST_Z1;
         end
         ST_Z1: state_in = z_move ? ST_Z2 : ST_Y1;
         ST_Z2: state_in = ST_Z_W;
         ST_Z_W: begin
            sp_z_in  = post_sat;
            state_in = ST_Y1;
         end
         ST_Y1: begin
            if (low_thr) begin
               sp_yaw_in = in_eyaw_ff;
               state_in  = ST_OUT;
            end else begin
               state_in = ST_Y2;
            end
         end
         ST_Y2: state_in = ST_Y_W;
         ST_Y_W: begin
            sp_yaw_in = post_sat;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         yaw_rate_ff <= '0;
         tick_ff     <= '0;
         leash_ff    <= '0;
         climb_ff    <= '0;
         planar_ff   <= '0;
         hover_ff    <= '0;
         sp_x_ff     <= '0;
         sp_y_ff     <= '0;
         sp_z_ff     <= '0;
         sp_yaw_ff   <= '0;
         spd_x_ff    <= '0;
         spd_y_ff    <= '0;
         roll_ff     <= '0;
         pitch_ff    <= '0;
         xthr_ff     <= '0;
         ythr_ff     <= '0;
         zthr_ff     <= '0;
         mask_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         sp_x_ff   <= sp_x_in;
         sp_y_ff   <= sp_y_in;
         sp_z_ff   <= sp_z_in;
         sp_yaw_ff <= sp_yaw_in;
         spd_x_ff  <= spd_x_in;
         spd_y_ff  <= spd_y_in;
         roll_ff   <= roll_in;
         pitch_ff  <= pitch_in;
         xthr_ff   <= xthr_in;
         ythr_ff   <= ythr_in;
         zthr_ff   <= zthr_in;
         mask_ff   <= mask_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAX_YAW_RATE:     yaw_rate_ff <= csr_data[30:0];
               CSR_TICK_PERIOD:      tick_ff     <= csr_data[15:0];
               CSR_LEASH_DISTANCE:   leash_ff    <= csr_data[30:0];
               CSR_MAX_CLIMB_SPEED:  climb_ff    <= csr_data[30:0];
               CSR_MAX_PLANAR_SPEED: planar_ff   <= csr_data[30:0];
               CSR_HOVER_THROTTLE:   hover_ff    <= $signed(csr_data[15:0]);
               default: ;
            endcase
         end
      end
   end

   // tick word latch and product register
   always_ff @(posedge clock) begin
      if (req_acc) begin
         in_mode_ff  <= req_data.fly_mode;
         in_roll_ff  <= req_data.roll_axis;
         in_pitch_ff <= req_data.pitch_axis;
         in_ystk_ff  <= req_data.yaw_axis;
         in_thr_ff   <= req_data.throttle_stick;
         in_ex_ff    <= req_data.est_x;
         in_ey_ff    <= req_data.est_y;
         in_eyaw_ff  <= req_data.est_yaw;
      end
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      rsp_data.sp_x        = sp_x_ff;
      rsp_data.sp_y        = sp_y_ff;
      rsp_data.sp_z        = sp_z_ff;
      rsp_data.sp_yaw      = sp_yaw_ff;
      rsp_data.sp_roll     = roll_ff;
      rsp_data.sp_pitch    = pitch_ff;
      rsp_data.thrust_x    = xthr_ff;
      rsp_data.thrust_y    = ythr_ff;
      rsp_data.thrust_z    = zthr_ff;
      rsp_data.x_speed_cmd = spd_x_ff;
      rsp_data.y_speed_cmd = spd_y_ff;
      rsp_data.enable_mask = mask_ff;
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ready)
      else $error("accepted a word while busy");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("ready for input while a result is pending");

   a_inactive_passthru: assert property (@(posedge clock) disable iff (reset)
      (req_acc && !req_data.active) |=> rsp_valid)
      else $error("inactive tick did not go straight to the result");

   a_yaw_snap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_Y1 && low_thr) |=> (sp_yaw_ff == $past(in_eyaw_ff)))
      else $error("yaw did not snap to estimate at low throttle");

   a_low_x_ends_xy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_XYX_W && !x_above && x_below) |=> (state_ff == ST_Z1))
      else $error("lower X clamp did not end the XY step");

endmodule
